>>> rtl/core/swm_pkg.sv
package swm_pkg;

    // Width of the window size write port (cfg_wr_data)
    localparam int CFG_WIDTH = 7;

    // Window size after reset
    localparam int RESET_WINDOW = 3;

    // Control from the pipeline front end to the sorted cell row
    typedef struct packed {
        logic commit;  // apply the held sample to the window
        logic clear;   // empty the window
    } cell_ctrl_t;

endpackage

>>> rtl/core/swm_cells.sv
module swm_cells #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32,
    parameter int CW           = $clog2(WINDOW_MAX + 1),
    parameter int IW           = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [CW-1:0]                  win,
    input  logic [IW-1:0]                  mid,
    output logic                           emit,
    output logic signed [SAMPLE_WIDTH-1:0] median
);
    import swm_pkg::*;

    // Row of cells kept in ascending order; each cell remembers how long ago it arrived
    logic signed [SAMPLE_WIDTH-1:0] val_reg [WINDOW_MAX];
    logic [IW-1:0]                  age_reg [WINDOW_MAX];
    logic [CW-1:0]                  count_reg;

    logic signed [SAMPLE_WIDTH-1:0] val_next [WINDOW_MAX];
    logic [IW-1:0]                  age_next [WINDOW_MAX];
    logic [CW-1:0]                  count_next;

    logic [WINDOW_MAX-1:0] vld;
    logic [WINDOW_MAX-1:0] rm;
    logic [WINDOW_MAX-1:0] gt;
    logic [WINDOW_MAX-1:0] rb;
    logic [WINDOW_MAX-1:0] keep;
    logic [WINDOW_MAX-1:0] from_up;
    logic [WINDOW_MAX-1:0] from_dn;
    logic                  full;
    logic [IW-1:0]         oldest_age;

    assign full       = (count_reg == win);
    assign oldest_age = IW'(win - CW'(1));

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++) begin : g_flag
            assign vld[i] = (CW'(i) < count_reg);
            assign rm[i]  = full && vld[i] && (age_reg[i] == oldest_age);
            assign gt[i]  = vld[i] && (sample < val_reg[i]);
        end
    endgenerate

    // Mark every cell above the one that drops out
    assign rb = (|rm) ? ~(rm | (rm - WINDOW_MAX'(1))) : '0;

    generate
        for (i = 0; i < WINDOW_MAX; i++) begin : g_src
            assign keep[i] = vld[i] && !rm[i] && (rb[i] == gt[i]);
            if (i + 1 < WINDOW_MAX) begin : g_up
                assign from_up[i] = vld[i+1] && !rm[i+1] && rb[i+1] && !gt[i+1];
            end else begin : g_up_none
                assign from_up[i] = 1'b0;
            end
            if (i > 0) begin : g_dn
                assign from_dn[i] = vld[i-1] && !rm[i-1] && !rb[i-1] && gt[i-1];
            end else begin : g_dn_none
                assign from_dn[i] = 1'b0;
            end

            always_comb
            begin
                // The one slot that no old cell lands in takes the new sample
                if (keep[i]) begin
                    val_next[i] = val_reg[i];
                    age_next[i] = age_reg[i] + IW'(1);
                end else if (from_up[i]) begin
                    val_next[i] = val_reg[(i + 1) % WINDOW_MAX];
                    age_next[i] = age_reg[(i + 1) % WINDOW_MAX] + IW'(1);
                end else if (from_dn[i]) begin
                    val_next[i] = val_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX];
                    age_next[i] = age_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX] + IW'(1);
                end else begin
                    val_next[i] = sample;
                    age_next[i] = '0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctrl.commit) begin
                    val_reg[i] <= val_next[i];
                    age_reg[i] <= age_next[i];
                end
            end
        end
    endgenerate

    assign count_next = full ? count_reg : count_reg + CW'(1);
    assign emit       = (count_next == win);
    assign median     = val_next[mid];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (ctrl.clear) begin
            count_reg <= '0;
        end else if (ctrl.commit) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/sliding_window_median.sv
// Running median over the last window_size samples, one sample per clock unless stalled.
// An accepted sample waits in sample_reg; its median is registered in median_reg on commit.
// Throughput: one item per cycle unless stalled; the sorted cell row updates in one pass.
// Reset: the window is emptied and window_size returns to 3 (saturated to WINDOW_MAX).
// A write to window_size also empties the window; results resume after window_size samples.
module sliding_window_median #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [swm_pkg::CFG_WIDTH-1:0]      cfg_wr_data,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic                               median_valid,
    input  logic                               median_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     median
);
    import swm_pkg::*;

    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WCMP = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
    localparam int RESET_WIN = (RESET_WINDOW > WINDOW_MAX) ? WINDOW_MAX : RESET_WINDOW;

    logic [CW-1:0]                  win_reg;
    logic [CW-1:0]                  win_next;
    logic [IW-1:0]                  mid_reg;
    logic [IW-1:0]                  mid_next;
    logic [WCMP-1:0]                cfg_wide;
    logic                           s_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;
    logic                           emit;
    logic signed [SAMPLE_WIDTH-1:0] cell_median;
    cell_ctrl_t                     ctrl;

    // Clamp the written size into 1..WINDOW_MAX
    assign cfg_wide = WCMP'(cfg_wr_data);

    always_comb
    begin
        if (cfg_wr_data == '0) begin
            win_next = CW'(1);
        end else if (cfg_wide > WCMP'(WINDOW_MAX)) begin
            win_next = CW'(WINDOW_MAX);
        end else begin
            win_next = CW'(cfg_wide);
        end
        mid_next = IW'((win_next - CW'(1)) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg <= CW'(RESET_WIN);
            mid_reg <= IW'((RESET_WIN - 1) / 2);
        end else if (cfg_wr_en) begin
            win_reg <= win_next;
            mid_reg <= mid_next;
        end
    end

    // Hold the sample only while its median cannot leave
    assign ctrl.commit  = s_valid_reg && (!emit || !m_valid_reg || median_ready);
    assign ctrl.clear   = cfg_wr_en;
    assign sample_ready = !s_valid_reg || ctrl.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_valid_reg <= 1'b0;
        end else if (sample_ready) begin
            s_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid) begin
            sample_reg <= sample;
        end
    end

    swm_cells #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW),
        .IW           (IW)
    ) u_cells (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (sample_reg),
        .win    (win_reg),
        .mid    (mid_reg),
        .emit   (emit),
        .median (cell_median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.commit && emit) begin
            m_valid_reg <= 1'b1;
        end else if (median_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && emit) begin
            median_reg <= cell_median;
        end
    end

    assign median_valid = m_valid_reg;
    assign median       = median_reg;

endmodule
